[src/mips_subset_execute_macros.svh]
// Assertion macros shared by the execute block modules.
// Each macro expects clk and rst_n in scope of the including module.
`ifndef MIPS_SUBSET_EXECUTE_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_MACROS_SVH

// condition must hold every cycle out of reset
`define MSE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define MSE_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mse_pkg.sv]
// Shared types and constants for the MIPS subset execute block.
// No dependencies; used by every module and the top level.
package mse_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int XLEN      = 32;

    // configuration port: two 32-bit registers at byte offsets 0 and 4
    localparam int PADDR_W   = 3;
    localparam int CFG_IDX_W = PADDR_W - 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PC   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SP = 1'b1;

    localparam logic [XLEN-1:0] START_PC_RESET   = 32'h0040_0000;
    localparam logic [XLEN-1:0] INITIAL_SP_RESET = 32'h7FFF_EFFC;
    localparam logic [XLEN-1:0] PC_STEP          = 32'd4;

    localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
    localparam logic [REG_AW-1:0] REG_V0   = 5'd2;
    localparam logic [REG_AW-1:0] REG_A0   = 5'd4;
    localparam logic [REG_AW-1:0] REG_A1   = 5'd5;
    localparam logic [REG_AW-1:0] REG_SP   = 5'd29;
    localparam logic [REG_AW-1:0] REG_RA   = 5'd31;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_LUI     = 6'h0F;

    // SPECIAL function codes
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_SLT  = 6'h2A;

    // syscall numbers taken from v0
    localparam logic [XLEN-1:0] SYS_PRINT_INT  = 32'd1;
    localparam logic [XLEN-1:0] SYS_PRINT_STR  = 32'd4;
    localparam logic [XLEN-1:0] SYS_READ_STR   = 32'd8;
    localparam logic [XLEN-1:0] SYS_EXIT       = 32'd10;
    localparam logic [XLEN-1:0] SYS_PRINT_CHAR = 32'd11;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_PRINT_INT   = 3'd1,
        EV_PRINT_STR   = 3'd2,
        EV_READ_STR    = 3'd3,
        EV_EXIT        = 3'd4,
        EV_PRINT_CHAR  = 3'd5,
        EV_BAD_SYSCALL = 3'd6,
        EV_ILLEGAL     = 3'd7
    } event_kind_t;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } wb_t;

    typedef struct packed {
        logic [XLEN-1:0] next_pc;
        logic            handled;
        event_kind_t     kind;
        logic [XLEN-1:0] arg0;
        logic [XLEN-1:0] arg1;
        logic            set_exit;
    } exec_res_t;

endpackage

[src/mse_ifs.sv]
// Valid/ready channel interfaces for instruction requests and results.
// Widths follow the fixed field widths; no package dependency.
interface mse_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface mse_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        handled;
    logic [2:0]  event_kind;
    logic [31:0] event_arg0;
    logic [31:0] event_arg1;
    logic        halted;

    modport source (output valid, output next_pc, output handled, output event_kind,
                    output event_arg0, output event_arg1, output halted, input ready);
    modport sink   (input valid, input next_pc, input handled, input event_kind,
                    input event_arg0, input event_arg1, input halted, output ready);
endinterface

[src/mse_core.sv]
// Decode and execute of one instruction word: next pc, event and writeback.
// Pure combinational; depends on mse_pkg.
module mse_core
    import mse_pkg::*;
(
    input  logic [XLEN-1:0] instruction,
    input  logic [XLEN-1:0] pc,
    input  logic [XLEN-1:0] a,
    input  logic [XLEN-1:0] b,
    input  logic [XLEN-1:0] v0,
    input  logic [XLEN-1:0] a0,
    input  logic [XLEN-1:0] a1,
    output exec_res_t       res,
    output wb_t             wb
);

    logic [5:0]        op;
    logic [5:0]        funct;
    logic [REG_AW-1:0] rt;
    logic [REG_AW-1:0] rd;
    logic [XLEN-1:0]   seq;
    logic [XLEN-1:0]   simm;
    logic [XLEN-1:0]   zimm;
    logic [XLEN-1:0]   br_target;
    logic [XLEN-1:0]   j_target;
    logic              illegal;

    assign op        = instruction[31:26];
    assign rt        = instruction[20:16];
    assign rd        = instruction[15:11];
    assign funct     = instruction[5:0];
    assign seq       = pc + PC_STEP;
    assign simm      = {{16{instruction[15]}}, instruction[15:0]};
    assign zimm      = {16'h0000, instruction[15:0]};
    assign br_target = seq + {simm[XLEN-3:0], 2'b00};
    assign j_target  = {seq[31:28], instruction[25:0], 2'b00};

    always_comb
    begin
        res.next_pc  = seq;
        res.handled  = 1'b0;
        res.kind     = EV_NONE;
        res.arg0     = '0;
        res.arg1     = '0;
        res.set_exit = 1'b0;
        wb.en        = 1'b0;
        wb.addr      = rd;
        wb.data      = a + b;
        illegal      = 1'b0;

        if (instruction == '0)
        begin
            // syscall, selected by v0
            res.arg0    = a0;
            res.arg1    = a1;
            res.handled = 1'b1;
            unique case (v0)
                SYS_PRINT_INT:  res.kind = EV_PRINT_INT;
                SYS_PRINT_STR:  res.kind = EV_PRINT_STR;
                SYS_READ_STR:   res.kind = EV_READ_STR;
                SYS_EXIT:
                begin
                    res.kind     = EV_EXIT;
                    res.set_exit = 1'b1;
                end
                SYS_PRINT_CHAR: res.kind = EV_PRINT_CHAR;
                default:
                begin
                    res.kind    = EV_BAD_SYSCALL;
                    res.handled = 1'b0;
                end
            endcase
        end
        else if (op == OP_SPECIAL)
        begin
            unique case (funct) inside
                FN_ADD, FN_ADDU:
                begin
                    wb.en   = 1'b1;
                    wb.data = a + b;
                end
                FN_SUB:
                begin
                    wb.en   = 1'b1;
                    wb.data = a - b;
                end
                FN_AND:
                begin
                    wb.en   = 1'b1;
                    wb.data = a & b;
                end
                FN_OR:
                begin
                    wb.en   = 1'b1;
                    wb.data = a | b;
                end
                FN_SLT:
                begin
                    wb.en   = 1'b1;
                    wb.data = {31'b0, $signed(a) < $signed(b)};
                end
                FN_JR:   res.next_pc = a;
                default: illegal = 1'b1;
            endcase
        end
        else
        begin
            unique case (op) inside
                OP_ADDI, OP_ADDIU:
                begin
                    wb.en   = 1'b1;
                    wb.addr = rt;
                    wb.data = a + simm;
                end
                OP_BEQ:
                begin
                    if (a == b)
                        res.next_pc = br_target;
                end
                OP_BNE:
                begin
                    if (a != b)
                        res.next_pc = br_target;
                end
                OP_ORI:
                begin
                    wb.en   = 1'b1;
                    wb.addr = rt;
                    wb.data = a | zimm;
                end
                OP_LUI:
                begin
                    wb.en   = 1'b1;
                    wb.addr = rt;
                    wb.data = {instruction[15:0], 16'h0000};
                end
                OP_J:    res.next_pc = j_target;
                OP_JAL:
                begin
                    wb.en       = 1'b1;
                    wb.addr     = REG_RA;
                    wb.data     = seq;
                    res.next_pc = j_target;
                end
                default: illegal = 1'b1;
            endcase
        end

        // illegal words leave all state alone and hold the pc
        if (illegal)
        begin
            res.next_pc = pc;
            res.kind    = EV_ILLEGAL;
            wb.en       = 1'b0;
        end

        if (wb.addr == REG_ZERO)
            wb.en = 1'b0;
    end

endmodule

[src/mse_regfile.sv]
// 32 x 32 register file: memory with registered reads of rs/rt, valid bits
// for the reset image, write bypass and copies of v0/a0/a1. Uses mse_pkg.
module mse_regfile
    import mse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [REG_AW-1:0] rs,
    input  logic [REG_AW-1:0] rt,
    input  wb_t               wb,
    input  logic              sp_load,
    input  logic [XLEN-1:0]   initial_sp,
    output logic [XLEN-1:0]   a,
    output logic [XLEN-1:0]   b,
    output logic [XLEN-1:0]   v0,
    output logic [XLEN-1:0]   a0,
    output logic [XLEN-1:0]   a1
);

`include "mips_subset_execute_macros.svh"

    logic [XLEN-1:0]      mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [REG_COUNT-1:0] valid_next;

    logic                 we;
    logic [REG_AW-1:0]    waddr;
    logic [XLEN-1:0]      wdata;

    logic [XLEN-1:0]      rd_a_reg;
    logic [XLEN-1:0]      rd_b_reg;
    logic                 a_zero_reg, a_byp_reg, a_vld_reg, a_sp_reg;
    logic                 b_zero_reg, b_byp_reg, b_vld_reg, b_sp_reg;
    logic [XLEN-1:0]      byp_data_reg;

    logic [XLEN-1:0]      v0_reg, a0_reg, a1_reg;

    assign we    = wb.en | sp_load;
    assign waddr = sp_load ? REG_SP : wb.addr;
    assign wdata = sp_load ? initial_sp : wb.data;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (rd_en)
        begin
            rd_a_reg <= mem[rs];
            rd_b_reg <= mem[rt];
        end
    end

    // operand source flags, captured with the read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            a_zero_reg   <= (rs == REG_ZERO);
            a_byp_reg    <= we && (waddr == rs);
            a_vld_reg    <= valid_reg[rs];
            a_sp_reg     <= (rs == REG_SP);
            b_zero_reg   <= (rt == REG_ZERO);
            b_byp_reg    <= we && (waddr == rt);
            b_vld_reg    <= valid_reg[rt];
            b_sp_reg     <= (rt == REG_SP);
            byp_data_reg <= wdata;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (we)
            valid_next[waddr] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            v0_reg    <= '0;
            a0_reg    <= '0;
            a1_reg    <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (we && waddr == REG_V0)
                v0_reg <= wdata;
            if (we && waddr == REG_A0)
                a0_reg <= wdata;
            if (we && waddr == REG_A1)
                a1_reg <= wdata;
        end
    end

    // never-written entries read their reset image: zero, sp = initial_sp
    always_comb
    begin
        if (a_zero_reg)
            a = '0;
        else if (a_byp_reg)
            a = byp_data_reg;
        else if (a_vld_reg)
            a = rd_a_reg;
        else if (a_sp_reg)
            a = initial_sp;
        else
            a = '0;

        if (b_zero_reg)
            b = '0;
        else if (b_byp_reg)
            b = byp_data_reg;
        else if (b_vld_reg)
            b = rd_b_reg;
        else if (b_sp_reg)
            b = initial_sp;
        else
            b = '0;
    end

    assign v0 = v0_reg;
    assign a0 = a0_reg;
    assign a1 = a1_reg;

    `MSE_ASSERT_IMPLIES(a_no_r0_write, wb.en, wb.addr != REG_ZERO, "write to r0")
    `MSE_ASSERT_ALWAYS(a_single_writer, !(sp_load && wb.en), "sp load collides with writeback")
    `MSE_ASSERT_NEXT(a_valid_after_write, we, valid_reg[$past(waddr)], "valid bit not set")

endmodule

[src/mips_subset_execute.sv]
// Top level of the MIPS integer subset execute block.
// Depends on mse_pkg, mse_ifs (channels), mse_regfile and mse_core.
//
// instr_in carries one 32-bit instruction word per request; result_out returns
// exactly one result per instruction, in order: next pc, syscall handled flag,
// event kind with a0/a1, and the sticky halted flag.
// A request accepted into the input register executes from there into the
// result register. Throughput: one instruction per cycle unless result_out
// stalls; the register file read happens at accept, the writeback and pc
// update at execute, one instruction apart, with a bypass from the writeback
// port covering back-to-back dependences. When result_out stalls, the result
// register holds, the instruction in the input register waits, and
// instr_in.ready drops once that register is full. Reset: pc = start_pc, r29 =
// initial_sp, other registers zero, halted clear, both channels empty. The APB
// port writes start_pc (offset 0, also loads the pc) and initial_sp (offset 4,
// also loads r29); writes are to be made by the user while idle, not enforced.
module mips_subset_execute
    import mse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [XLEN-1:0]    pwdata,
    output logic [XLEN-1:0]    prdata,
    output logic               pready,
    mse_instr_if.sink          instr_in,
    mse_result_if.source       result_out
);

`include "mips_subset_execute_macros.svh"

    logic                 cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;

    logic [XLEN-1:0]      start_pc_reg;
    logic [XLEN-1:0]      initial_sp_reg;
    logic [XLEN-1:0]      pc_reg, pc_next;
    logic                 exit_reg, exit_next;

    logic                 in_valid_reg, in_valid_next;
    logic [XLEN-1:0]      instr_reg;
    logic                 out_valid_reg, out_valid_next;

    logic                 in_fire;
    logic                 exec_fire;

    logic [XLEN-1:0]      op_a, op_b, v0, a0, a1;
    exec_res_t            ex;
    wb_t                  core_wb;
    wb_t                  wb;

    logic [XLEN-1:0]      next_pc_reg;
    logic                 handled_reg;
    event_kind_t          kind_reg;
    logic [XLEN-1:0]      arg0_reg, arg1_reg;
    logic                 halted_reg;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb
    begin
        unique case (cfg_idx)
            CFG_START_PC:   prdata = start_pc_reg;
            CFG_INITIAL_SP: prdata = initial_sp_reg;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg   <= START_PC_RESET;
            initial_sp_reg <= INITIAL_SP_RESET;
        end
        else if (cfg_wr)
        begin
            if (cfg_idx == CFG_START_PC)
                start_pc_reg <= pwdata;
            if (cfg_idx == CFG_INITIAL_SP)
                initial_sp_reg <= pwdata;
        end
    end

    // handshake: input register feeds execute, result register feeds output
    assign exec_fire      = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign instr_in.ready = !in_valid_reg || exec_fire;
    assign in_fire        = instr_in.valid && instr_in.ready;

    assign in_valid_next  = in_fire | (in_valid_reg & ~exec_fire);
    assign out_valid_next = exec_fire | (out_valid_reg & ~result_out.ready);

    always_comb
    begin
        pc_next = pc_reg;
        if (exec_fire)
            pc_next = ex.next_pc;
        else if (cfg_wr && cfg_idx == CFG_START_PC)
            pc_next = pwdata;
    end

    assign exit_next = exit_reg | (exec_fire & ex.set_exit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= START_PC_RESET;
            exit_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
            exit_reg      <= exit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            instr_reg <= instr_in.instruction;
        if (exec_fire)
        begin
            next_pc_reg <= ex.next_pc;
            handled_reg <= ex.handled;
            kind_reg    <= ex.kind;
            arg0_reg    <= ex.arg0;
            arg1_reg    <= ex.arg1;
            halted_reg  <= exit_next;
        end
    end

    always_comb
    begin
        wb    = core_wb;
        wb.en = core_wb.en & exec_fire;
    end

    mse_regfile u_regfile (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (in_fire),
        .rs         (instr_in.instruction[25:21]),
        .rt         (instr_in.instruction[20:16]),
        .wb         (wb),
        .sp_load    (cfg_wr && cfg_idx == CFG_INITIAL_SP),
        .initial_sp (cfg_wr && cfg_idx == CFG_INITIAL_SP ? pwdata : initial_sp_reg),
        .a          (op_a),
        .b          (op_b),
        .v0         (v0),
        .a0         (a0),
        .a1         (a1)
    );

    mse_core u_core (
        .instruction (instr_reg),
        .pc          (pc_reg),
        .a           (op_a),
        .b           (op_b),
        .v0          (v0),
        .a0          (a0),
        .a1          (a1),
        .res         (ex),
        .wb          (core_wb)
    );

    assign result_out.valid      = out_valid_reg;
    assign result_out.next_pc    = next_pc_reg;
    assign result_out.handled    = handled_reg;
    assign result_out.event_kind = kind_reg;
    assign result_out.event_arg0 = arg0_reg;
    assign result_out.event_arg1 = arg1_reg;
    assign result_out.halted     = halted_reg;

    `MSE_ASSERT_NEXT(a_illegal_holds_pc, exec_fire && ex.kind == EV_ILLEGAL, pc_reg == $past(pc_reg), "illegal moved pc")
    `MSE_ASSERT_NEXT(a_halt_sticky, exit_reg, exit_reg, "halted flag cleared")
    `MSE_ASSERT_NEXT(a_exec_gives_result, exec_fire, out_valid_reg, "executed item has no result")
    `MSE_ASSERT_IMPLIES(a_handled_kind, ex.handled, ex.kind != EV_NONE && ex.kind != EV_BAD_SYSCALL && ex.kind != EV_ILLEGAL, "handled with bad kind")
    `MSE_ASSERT_IMPLIES(a_no_overrun, in_valid_reg && !exec_fire, !instr_in.ready, "input register overrun")

endmodule
